[src/keyed_count_hash_table_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the keyed count hash table
// Implication forms for keyed_count_hash_table, which checks its own logic.
// ----------------------------------------------------------------------------
`ifndef KEYED_COUNT_HASH_TABLE_ASSERT_SVH
`define KEYED_COUNT_HASH_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KCHT_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KCHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/kcht_pkg.sv]
// ----------------------------------------------------------------------------
// kcht_pkg
// Types and fixed constants of the keyed count hash table.
// ----------------------------------------------------------------------------
package kcht_pkg;

  localparam int KEY_W    = 31;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 7;
  localparam int REG_IDX_W = 1;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_TABLE_SIZE   = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_HASH_DIVISOR = 1'd1;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST   = 7'd64;
  localparam logic [CFG_W-1:0] HASH_DIVISOR_RST = 7'd61;

  // Remainder unit: radix-16 restoring steps over a zero-extended key
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = 8;
  localparam int DIV_CNT_W      = 3;
  localparam int DVD_W          = DIV_STEPS * DIV_RADIX_BITS;

  typedef enum logic [KIND_W-1:0] {
    K_LOOKUP = 2'd0,
    K_STOCK  = 2'd1,
    K_TAKE   = 2'd2,
    K_GIVE   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_FULL       = 3'd2,
    ST_NONE_AVAIL = 3'd3,
    ST_SATURATED  = 3'd4
  } status_t;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_DIV  = 6'b000100,
    S_RD   = 6'b001000,
    S_CK   = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

endpackage

[src/kcht_ram.sv]
// ----------------------------------------------------------------------------
// kcht_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kcht_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/keyed_count_hash_table.sv]
// ----------------------------------------------------------------------------
// keyed_count_hash_table
// Hash table of nonzero keys with linear probing, each entry holding an
// available count and a total count.
//
// Input channel (in_valid / in_stall): one operation per transaction, kind
// plus key. Result channel (out_valid / out_stall): exactly one result per
// operation, in order. Config port: cfg_we writes table_size (index 0) or
// hash_divisor (index 1); write only while the block is idle.
// Flow: the home slot comes from a remainder unit (4 key bits per cycle),
// then the probe reads one slot per cycle from the entry RAM, visiting
// 1..table_size slots; the next item is accepted in the cycle after the
// result is registered. A zero key skips the remainder unit and the probe
// and goes straight to the final state.
// Reset (synchronous, rst_n low) clears control state, then a clearing pass
// writes all TABLE_DEPTH entries to zero, one per cycle, with in_stall high.
// A stalled result is held in the output register; the next operation runs
// meanwhile and waits in its final state until the output register frees.
// ----------------------------------------------------------------------------
`include "keyed_count_hash_table_assert.svh"

module keyed_count_hash_table
  import kcht_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int COUNT_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [REG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [KIND_W-1:0]              in_kind,
  input  logic [KEY_W-1:0]               in_item_key,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [STATUS_W-1:0]            out_status,
  output logic                           out_found,
  output logic [$clog2(TABLE_DEPTH)-1:0] out_slot,
  output logic [COUNT_BITS-1:0]          out_available_count,
  output logic [COUNT_BITS-1:0]          out_total_count
);

  localparam int AW         = $clog2(TABLE_DEPTH);
  localparam int CB         = COUNT_BITS;
  localparam int ENTRY_W    = KEY_W + 2 * CB;
  localparam int SIZE_CAP_I = (TABLE_DEPTH > 127) ? 127 : TABLE_DEPTH;
  localparam logic [CFG_W-1:0]     SIZE_CAP  = CFG_W'(SIZE_CAP_I);
  localparam logic [AW-1:0]        CLR_LAST  = AW'(TABLE_DEPTH - 1);
  localparam logic [DIV_CNT_W-1:0] STEP_LAST = DIV_CNT_W'(DIV_STEPS - 1);
  localparam logic [CB-1:0]        CMAX      = '1;
  localparam logic [CB-1:0]        CONE      = CB'(1);

  state_t                 state_r, state_nxt;
  logic [CFG_W-1:0]       size_r, div_r, occ_r, cnt_r, rem_r;
  logic [AW-1:0]          clr_r, d_r;
  logic [DIV_CNT_W-1:0]   step_r;
  kind_t                  kind_r;
  logic [KEY_W-1:0]       key_r;
  logic [DVD_W-1:0]       dvd_r;

  status_t                res_status_r, out_status_r;
  logic                   res_found_r, out_found_r;
  logic [AW-1:0]          res_slot_r, out_slot_r;
  logic [CB-1:0]          res_av_r, res_tot_r, out_av_r, out_tot_r;
  logic                   out_valid_r;

  logic [CFG_W-1:0]       size_use, div_use, rem_nxt;
  logic [AW:0]            d_inc;
  logic [AW-1:0]          d_step;
  logic                   in_accept, out_free;

  logic [ENTRY_W-1:0]     ram_rdata, ram_wdata, wdata_c;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic                   ram_we, ram_re;

  logic [KEY_W-1:0]       ent_key;
  logic [CB-1:0]          ent_av, ent_tot, av_inc, tot_inc;
  logic                   av_sat, tot_sat;
  logic                   hit, empty, last, probe_done;
  status_t                status_c;
  logic [AW-1:0]          slot_c;
  logic [CB-1:0]          av_c, tot_c;
  logic                   wr_c, insert_c, occ_inc;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // Clamp the registers to the range in use
  always_comb begin
    if (size_r == '0) begin
      size_use = CFG_W'(1);
    end else if (size_r > SIZE_CAP) begin
      size_use = SIZE_CAP;
    end else begin
      size_use = size_r;
    end
    if (div_r == '0) begin
      div_use = CFG_W'(1);
    end else if (div_r > size_use) begin
      div_use = size_use;
    end else begin
      div_use = div_r;
    end
  end

  // Restoring remainder, DIV_RADIX_BITS key bits per cycle
  always_comb begin
    logic [CFG_W:0] trial;
    rem_nxt = rem_r;
    for (int j = 0; j < DIV_RADIX_BITS; j++) begin
      trial = {rem_nxt, dvd_r[DVD_W-1-j]};
      if (trial >= {1'b0, div_use}) begin
        rem_nxt = CFG_W'(trial - {1'b0, div_use});
      end else begin
        rem_nxt = trial[CFG_W-1:0];
      end
    end
  end

  // Next probe slot, wrapping at the size in use
  assign d_inc  = {1'b0, d_r} + (AW+1)'(1);
  assign d_step = (32'(d_inc) >= 32'(size_use)) ? '0 : d_inc[AW-1:0];

  // Check the slot read last cycle
  assign ent_key    = ram_rdata[ENTRY_W-1 -: KEY_W];
  assign ent_av     = ram_rdata[2*CB-1 -: CB];
  assign ent_tot    = ram_rdata[CB-1:0];
  assign hit        = (ent_key == key_r);
  assign empty      = (ent_key == '0);
  assign last       = ((cnt_r + CFG_W'(1)) == size_use);
  assign probe_done = hit || empty || last;
  assign av_sat     = (ent_av == CMAX);
  assign tot_sat    = (ent_tot == CMAX);
  assign av_inc     = av_sat ? CMAX : ent_av + CONE;
  assign tot_inc    = tot_sat ? CMAX : ent_tot + CONE;

  always_comb begin
    status_c = ST_OK;
    slot_c   = hit ? d_r : '0;
    av_c     = hit ? ent_av : '0;
    tot_c    = hit ? ent_tot : '0;
    wr_c     = 1'b0;
    insert_c = 1'b0;
    wdata_c  = {key_r, ent_av, ent_tot};
    case (kind_r)
      K_STOCK: begin
        if (occ_r >= size_use || !(hit || empty)) begin
          status_c = ST_FULL;
        end else if (hit) begin
          av_c    = av_inc;
          tot_c   = tot_inc;
          wr_c    = 1'b1;
          wdata_c = {key_r, av_inc, tot_inc};
          if (av_sat || tot_sat) begin
            status_c = ST_SATURATED;
          end
        end else begin
          insert_c = 1'b1;
          wr_c     = 1'b1;
          wdata_c  = {key_r, CONE, CONE};
          slot_c   = d_r;
          av_c     = CONE;
          tot_c    = CONE;
        end
      end
      K_TAKE: begin
        if (!hit) begin
          status_c = ST_NOT_FOUND;
        end else if (ent_av == '0) begin
          status_c = ST_NONE_AVAIL;
        end else begin
          av_c    = ent_av - CONE;
          wr_c    = 1'b1;
          wdata_c = {key_r, ent_av - CONE, ent_tot};
        end
      end
      K_GIVE: begin
        if (!hit) begin
          status_c = ST_NOT_FOUND;
        end else begin
          av_c    = av_inc;
          wr_c    = 1'b1;
          wdata_c = {key_r, av_inc, ent_tot};
          if (av_sat) begin
            status_c = ST_SATURATED;
          end
        end
      end
      K_LOOKUP: begin
        if (!hit) begin
          status_c = ST_NOT_FOUND;
        end
      end
      default: begin
        status_c = ST_NOT_FOUND;
      end
    endcase
  end

  assign occ_inc = (state_r == S_CK) && probe_done && insert_c;

  // Entry RAM ports
  assign ram_re    = (state_r == S_RD) || ((state_r == S_CK) && !probe_done);
  assign ram_raddr = (state_r == S_CK) ? d_step : d_r;
  assign ram_we    = (state_r == S_CLR) || ((state_r == S_CK) && probe_done && wr_c);
  assign ram_waddr = (state_r == S_CLR) ? clr_r : d_r;
  assign ram_wdata = (state_r == S_CLR) ? '0 : wdata_c;

  kcht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_item_key == '0) ? S_FIN : S_DIV;
        end
      end
      S_DIV: begin
        if (step_r == STEP_LAST) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CK;
      end
      S_CK: begin
        if (probe_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      size_r      <= TABLE_SIZE_RST;
      div_r       <= HASH_DIVISOR_RST;
      occ_r       <= '0;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_TABLE_SIZE:   size_r <= cfg_wdata;
          REG_HASH_DIVISOR: div_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_CLR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (occ_inc) begin
        occ_r <= occ_r + CFG_W'(1);
      end
      if (in_accept) begin
        step_r <= '0;
      end else if (state_r == S_DIV) begin
        step_r <= step_r + DIV_CNT_W'(1);
      end
      if (state_r == S_DIV) begin
        cnt_r <= '0;
      end else if (state_r == S_CK && !probe_done) begin
        cnt_r <= cnt_r + CFG_W'(1);
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= kind_t'(in_kind);
      key_r  <= in_item_key;
      dvd_r  <= DVD_W'(in_item_key);
      rem_r  <= '0;
      if (in_item_key == '0) begin
        res_status_r <= ST_NOT_FOUND;
        res_found_r  <= 1'b0;
        res_slot_r   <= '0;
        res_av_r     <= '0;
        res_tot_r    <= '0;
      end
    end
    if (state_r == S_DIV) begin
      dvd_r <= dvd_r << DIV_RADIX_BITS;
      rem_r <= rem_nxt;
      if (step_r == STEP_LAST) begin
        d_r <= AW'(rem_nxt);
      end
    end
    if (state_r == S_CK) begin
      if (probe_done) begin
        res_status_r <= status_c;
        res_found_r  <= hit;
        res_slot_r   <= slot_c;
        res_av_r     <= av_c;
        res_tot_r    <= tot_c;
      end else begin
        d_r <= d_step;
      end
    end
    if (state_r == S_FIN && out_free) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_slot_r   <= res_slot_r;
      out_av_r     <= res_av_r;
      out_tot_r    <= res_tot_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_found           = out_found_r;
  assign out_slot            = out_slot_r;
  assign out_available_count = out_av_r;
  assign out_total_count     = out_tot_r;

  `KCHT_ASSERT_HOLDS(a_probe_in_range, state_r == S_CK, 32'(d_r) < 32'(size_use), "probe slot beyond table size")
  `KCHT_ASSERT_HOLDS(a_probe_bounded, state_r == S_CK, cnt_r < size_use, "probe walked past table size")
  `KCHT_ASSERT_HOLDS(a_insert_room, occ_inc, occ_r < size_use, "insert with table full")
  `KCHT_ASSERT_NEXT(a_occ_step, occ_inc, occ_r == $past(occ_r) + CFG_W'(1), "occupancy did not advance")

endmodule
